// File: design/s2a_pkg.sv
`timescale 1ns / 1ps

package s2a_pkg;

	// Field widths of the two channels.
	localparam int ValueWidth = 32;
	localparam int CodeWidth  = 6;

	// Decimal digits needed for the largest magnitude, 2^31.
	localparam int NumDigits  = 10;
	localparam int DigIdxW    = $clog2(NumDigits);
	localparam int BitCntW    = $clog2(ValueWidth);

	// ASCII codes that the block emits.
	localparam logic [CodeWidth-1:0] CharMinus = 6'd45;
	localparam logic [CodeWidth-1:0] CharZero  = 6'd48;

	typedef logic [3:0] digit_t;

	// Conversion sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGITS
	} state_t;

endpackage

// File: design/s2a_channels_if.sv
`timescale 1ns / 1ps

// Input channel: one signed integer per beat.
interface s2a_num_if
	import s2a_pkg::*;
();
	logic                         valid;
	logic                         ready;
	logic signed [ValueWidth-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// Output channel: one ASCII character per beat.
interface s2a_text_if
	import s2a_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CodeWidth-1:0] char_code;
	logic                 last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// File: design/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Converts one signed 32-bit integer per input beat into its decimal ASCII text, most
// significant character first, with a leading minus for negative values, no leading
// zeros, and last_char set on the final character. The magnitude is taken unsigned, so
// the most negative value comes out as "-2147483648". Each number is accepted, then
// converted by bit-serial binary-to-BCD conversion (one magnitude bit shifted into ten
// BCD digits per cycle, with add-3 correction), and then emitted as 1 to 11 characters,
// each held in the output register until it is taken. The next number is accepted as
// soon as the last character of the previous one sits in the output register.
module signed_int_to_decimal_ascii
	import s2a_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	s2a_num_if.sink    num,
	s2a_text_if.source text
);

	state_t                  state_q, state_d;
	logic [ValueWidth-1:0]   mag_q;
	logic                    neg_q;
	digit_t                  bcd_q [NumDigits];
	digit_t                  bcd_next [NumDigits];
	logic [BitCntW-1:0]      bit_cnt_q;
	logic [DigIdxW-1:0]      dig_idx_q;
	logic [DigIdxW-1:0]      top_idx;

	logic                    out_valid_q;
	logic [CodeWidth-1:0]    out_code_q;
	logic                    out_last_q;

	logic                    out_free;
	logic                    accept;
	logic                    conv_done;
	logic                    emit_en;
	logic [CodeWidth-1:0]    emit_code;
	logic                    emit_last;

	assign out_free  = !out_valid_q || text.ready;
	assign accept    = num.valid && num.ready;
	assign conv_done = (bit_cnt_q == BitCntW'(ValueWidth - 1));

	// One double-dabble step: add 3 to every digit of 5 or more, then shift left by one
	// bit with the next magnitude bit entering the least significant digit.
	always_comb begin
		digit_t adj [NumDigits];
		for (int i = 0; i < NumDigits; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		bcd_next[0] = {adj[0][2:0], mag_q[ValueWidth-1]};
		for (int i = 1; i < NumDigits; i++) begin
			bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
		end
	end

	// Position of the most significant nonzero digit after the final step; zero gives
	// the single digit at position 0.
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NumDigits; i++) begin
			if (bcd_next[i] != 4'd0) begin
				top_idx = DigIdxW'(i);
			end
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					state_d = neg_q ? ST_SIGN : ST_DIGITS;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (out_free && dig_idx_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		num.ready = 1'b0;
		emit_en   = 1'b0;
		emit_code = CharZero;
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				num.ready = 1'b1;
			end
			ST_SIGN: begin
				emit_en   = out_free;
				emit_code = CharMinus;
			end
			ST_DIGITS: begin
				emit_en   = out_free;
				emit_code = CharZero + {{(CodeWidth - 4){1'b0}}, bcd_q[dig_idx_q]};
				emit_last = (dig_idx_q == '0);
			end
			default: begin
				num.ready = 1'b0;
			end
		endcase
	end

	// Sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				bit_cnt_q <= '0;
			end else if (state_q == ST_CONV) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			if (state_q == ST_CONV && conv_done) begin
				dig_idx_q <= top_idx;
			end else if (state_q == ST_DIGITS && out_free && dig_idx_q != '0) begin
				dig_idx_q <= dig_idx_q - 1'b1;
			end
		end
	end

	// Magnitude shift register and BCD digits.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= num.value[ValueWidth-1];
			mag_q <= num.value[ValueWidth-1] ? ValueWidth'(-num.value) : num.value;
			for (int i = 0; i < NumDigits; i++) begin
				bcd_q[i] <= 4'd0;
			end
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[ValueWidth-2:0], 1'b0};
			bcd_q <= bcd_next;
		end
	end

	// Output register: holds one beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit_en;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			out_code_q <= emit_code;
			out_last_q <= emit_last;
		end
	end

	assign text.valid     = out_valid_q;
	assign text.char_code = out_code_q;
	assign text.last_char = out_last_q;

endmodule

// File: tb/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;
	import s2a_pkg::*;

	localparam int Radix         = 10;
	localparam int RandomNumbers = 400;
	localparam int HoldOffCycles = 400;
	localparam int HoldOffAfter  = 150;
	localparam int StallLimit    = 3000;
	localparam int TailCycles    = 60;

	// One expected character of the decimal text.
	typedef struct packed {
		logic [CodeWidth-1:0] code;
		logic                 last;
	} ascii_char_t;

	// Expected text of every number the block has taken, in emission order.
	class text_scoreboard;
		ascii_char_t expected_text[$];
		int unsigned errors;
		int unsigned numbers;
		int unsigned negatives;
		int unsigned chars;

		function new();
			errors    = 0;
			numbers   = 0;
			negatives = 0;
			chars     = 0;
		endfunction

		// Builds the decimal text of an accepted number and queues its characters.
		function void note_number(logic signed [ValueWidth-1:0] num_value);
			logic [ValueWidth-1:0] magnitude;
			digit_t                digs[NumDigits];
			int                    ndig;
			int                    i;
			bit                    negative;
			ascii_char_t           c;

			negative  = num_value[ValueWidth-1];
			magnitude = num_value;
			// Unsigned magnitude, so the most negative value needs no special handling.
			if (negative) begin
				magnitude = ~num_value + 1'b1;
			end
			ndig = 0;
			do begin
				digs[ndig] = digit_t'(magnitude % Radix);
				ndig++;
				magnitude = magnitude / Radix;
			end while (magnitude != 0 && ndig < NumDigits);

			if (negative) begin
				c.code = CharMinus;
				c.last = 1'b0;
				expected_text.push_back(c);
				negatives++;
			end
			for (i = ndig - 1; i >= 0; i--) begin
				c.code = CharZero + digs[i];
				c.last = (i == 0);
				expected_text.push_back(c);
			end
			numbers++;
		endfunction

		// Compares one output beat with the oldest expected character.
		function void check_char(logic [CodeWidth-1:0] code, logic last);
			ascii_char_t exp_c;

			chars++;
			if (expected_text.size() == 0) begin
				$error("char_code: no character expected, got %0d (last_char %0d)", code, last);
				errors++;
				return;
			end
			exp_c = expected_text.pop_front();
			if (code !== exp_c.code) begin
				$error("char_code mismatch: expected %0d, got %0d", exp_c.code, code);
				errors++;
			end
			if (last !== exp_c.last) begin
				$error("last_char mismatch: expected %0d, got %0d", exp_c.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_text.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	s2a_num_if  num_ch ();
	s2a_text_if text_ch ();

	signed_int_to_decimal_ascii uut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.text   (text_ch)
	);

	text_scoreboard sb = new();

	int unsigned idle_cycles;
	bit          held_off;

	// Free-running clock, 8 ns period.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;

		r = $urandom_range(99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 10);
	endfunction

	// Random number: full-range bits, a chosen digit count, or near a power of ten.
	function automatic logic signed [ValueWidth-1:0] pick_number();
		logic [ValueWidth-1:0] mag;
		longint                lo;
		longint                hi;
		int unsigned           ndig;
		int unsigned           kind;
		int                    i;

		kind = $urandom_range(9);
		if (kind < 4) begin
			return $urandom;
		end
		ndig = $urandom_range(NumDigits, 1);
		lo   = 1;
		for (i = 1; i < ndig; i++) begin
			lo = lo * Radix;
		end
		hi = lo * Radix - 1;
		if (hi > 64'd2147483647) begin
			hi = 64'd2147483647;
		end
		if (kind < 9) begin
			mag = $urandom_range(32'(hi), 32'(lo));
		end else begin
			mag = ($urandom_range(1)) ? 32'(lo) : 32'(lo - 1);
		end
		return ($urandom_range(1)) ? -$signed(mag) : $signed(mag);
	endfunction

	// Offers one number and holds it until the block takes it.
	task automatic send_number(logic signed [ValueWidth-1:0] num_value);
		num_ch.valid <= 1'b1;
		num_ch.value <= num_value;
		do begin
			@(posedge clk);
		end while (num_ch.ready !== 1'b1);
		sb.note_number(num_value);
		@(negedge clk);
	endtask

	// Drops valid for a number of cycles, with junk on the payload.
	task automatic pause_sender(int unsigned cycles);
		if (cycles > 0) begin
			num_ch.valid <= 1'b0;
			num_ch.value <= $urandom;
			repeat (cycles) @(negedge clk);
		end
	endtask

	// Main stimulus: reset, corner numbers, random numbers, then drain.
	initial begin
		logic signed [ValueWidth-1:0] corner_numbers[] = '{
			32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
			-32'sd5, 32'sd2147483647, 32'h80000000, -32'sd2147483647, 32'sd1000000000,
			32'sd999999999, -32'sd999999999, -32'sd1000000000, 32'sd123456789,
			32'h55555555, 32'hAAAAAAAA, 32'sd1000000001, 32'hFFFF0000, 32'sd65535
		};
		int n;

		arst_n       = 1'b0;
		num_ch.valid = 1'b0;
		num_ch.value = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (corner_numbers[k]) begin
			send_number(corner_numbers[k]);
			pause_sender(($urandom_range(3) == 0) ? pick_gap() : 0);
		end

		// Every fourth block of fifty numbers goes back to back.
		for (n = 0; n < RandomNumbers; n++) begin
			send_number(pick_number());
			pause_sender(((n / 50) % 4 == 1) ? 0 : pick_gap());
		end
		num_ch.valid <= 1'b0;

		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (TailCycles) @(posedge clk);

		$display("Checked %0d numbers (%0d negative) as %0d characters.",
			sb.numbers, sb.negatives, sb.chars);
		$display("Corner values, random digit counts and one long output stall were covered.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[signed_int_to_decimal_ascii] OK");
		end else begin
			$display("[signed_int_to_decimal_ascii] ERROR");
		end
		$finish;
	end

	// Receiver: random ready runs, plus one long hold-off once 150 numbers have been taken.
	initial begin
		int unsigned run;

		text_ch.ready = 1'b0;
		held_off      = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && sb.numbers >= HoldOffAfter) begin
				text_ch.ready <= 1'b0;
				repeat (HoldOffCycles) @(negedge clk);
				held_off = 1'b1;
			end else if ($urandom_range(7) == 0) begin
				// Stretch with the receiver always ready.
				text_ch.ready <= 1'b1;
				repeat ($urandom_range(120, 40)) @(negedge clk);
			end else begin
				run = pick_gap();
				if (run > 0) begin
					text_ch.ready <= 1'b0;
					repeat (run) @(negedge clk);
				end
				text_ch.ready <= 1'b1;
				repeat ($urandom_range(6, 1) - 1) @(negedge clk);
			end
		end
	end

	// Checks every character beat the block hands over.
	always @(posedge clk) begin
		if (arst_n && text_ch.valid === 1'b1 && text_ch.ready === 1'b1) begin
			sb.check_char(text_ch.char_code, text_ch.last_char);
		end
	end

	// Watchdog on cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (num_ch.valid === 1'b1 && num_ch.ready === 1'b1) ||
			(text_ch.valid === 1'b1 && text_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("No beat accepted for %0d cycles.", idle_cycles);
			$display("[signed_int_to_decimal_ascii] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// File: files.f
design/s2a_pkg.sv
design/s2a_channels_if.sv
design/signed_int_to_decimal_ascii.sv
tb/tb_signed_int_to_decimal_ascii.sv
